/* rtl/core/olt_pkg.sv */
// ----------------------------------------------------------------------------
// olt_pkg: shared types and codes for the ordered list table
// Holds the request and result word layouts, request kinds, status codes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

    // Default capacity of the list.
    localparam int OLT_DEPTH = 16;

    // Request kinds.
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_INSERT     = 3'd4;
    localparam logic [2:0] REQ_ERASE      = 3'd5;
    localparam logic [2:0] REQ_READ       = 3'd6;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Kind of list operation once a request has been decoded.
    typedef enum logic [1:0] {
        CLS_OPEN  = 2'd0,
        CLS_CLOSE = 2'd1,
        CLS_READ  = 2'd2
    } t_cls;

    // Request word.
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value_in;
        logic [4:0]         index_in;
    } t_req;

    // Result word.
    typedef struct packed {
        logic signed [31:0] value_out;
        logic [4:0]         count;
        logic               is_empty;
        logic [1:0]         status;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic rd;
        logic wr;
        logic put;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        t_cls cls;
        logic more;
    } t_stat;

endpackage

/* rtl/core/ordered_list_table.sv */
// The result strobe is registered from the finish step. An error goes from the
// check straight to the finish and a read reads its entry and then finishes;
// other operations read and write back each shifted entry (none for a pop back).
// Push and insert then put the new value. One request at a time; entries move
// one at a time through the entry memory. The receiver cannot stall.
// Reset (synchronous, active low) empties the list; entry contents are kept.
// ----------------------------------------------------------------------------
// ordered_list_table: bounded ordered list of signed 32-bit entries
// Supports push and pop at both ends, insert, erase and read at a position,
// keeping the list contiguous by shifting entries.
// ----------------------------------------------------------------------------
module ordered_list_table #(
    parameter int DEPTH = olt_pkg::OLT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  olt_pkg::t_req i_req,
    output olt_pkg::t_res o_result,
    output logic          o_strobe
);
    import olt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    olt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Storage and decode.
    olt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

/* rtl/core/olt_datapath.sv */
// ----------------------------------------------------------------------------
// olt_datapath: list storage, count and request decode
// Holds the entry memory, the entry count and the move pointer, decodes the
// latched request into an operation and builds the result word.
// ----------------------------------------------------------------------------
module olt_datapath #(
    parameter int DEPTH = olt_pkg::OLT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  olt_pkg::t_req i_req,
    input  olt_pkg::t_cmd i_cmd,
    output olt_pkg::t_stat o_stat,
    output olt_pkg::t_res o_result,
    output logic          o_strobe
);
    import olt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > 5) ? CW : 5;

    logic [31:0]   mem [DEPTH];

    logic [2:0]    r_kind;
    logic [31:0]   r_val;
    logic [4:0]    r_idx;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [31:0]   r_rdata;
    t_res          r_result;
    logic          r_strobe;

    t_status       w_status;
    t_cls          w_cls;
    logic [CW-1:0] w_at;
    logic          w_full;
    logic          w_zero;
    logic [XW-1:0] w_idx_x;
    logic [XW-1:0] w_cnt_x;
    logic [CW:0]   w_ptr_inc;
    logic [CW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_ptr;
    t_res          n_result;

    // Decode the latched request against the current count.
    always_comb begin
        w_full  = (r_count == CW'(DEPTH));
        w_zero  = (r_count == '0);
        w_idx_x = XW'(r_idx);
        w_cnt_x = XW'(r_count);
        w_status = ST_OK;
        w_cls    = CLS_READ;
        w_at     = '0;
        case (r_kind)
            REQ_PUSH_FRONT: begin
                w_cls = CLS_OPEN;
                if (w_full) w_status = ST_FULL;
            end
            REQ_PUSH_BACK: begin
                w_cls = CLS_OPEN;
                w_at  = r_count;
                if (w_full) w_status = ST_FULL;
            end
            REQ_POP_FRONT: begin
                w_cls = CLS_CLOSE;
                if (w_zero) w_status = ST_EMPTY;
            end
            REQ_POP_BACK: begin
                w_cls = CLS_CLOSE;
                w_at  = r_count - 1'b1;
                if (w_zero) w_status = ST_EMPTY;
            end
            REQ_INSERT: begin
                w_cls = CLS_OPEN;
                w_at  = w_idx_x[CW-1:0];
                if (w_full)                 w_status = ST_FULL;
                else if (w_idx_x > w_cnt_x) w_status = ST_BADPOS;
            end
            REQ_ERASE: begin
                w_cls = CLS_CLOSE;
                w_at  = w_idx_x[CW-1:0];
                if (w_idx_x >= w_cnt_x) w_status = ST_BADPOS;
            end
            REQ_READ: begin
                w_cls = CLS_READ;
                w_at  = w_idx_x[CW-1:0];
                if (w_idx_x >= w_cnt_x) w_status = ST_BADPOS;
            end
            default: begin
                w_status = ST_BADPOS;
            end
        endcase
    end

    // Status to the controller: error, operation kind and whether another entry still has to move.
    always_comb begin
        w_ptr_inc = {1'b0, r_ptr} + 1'b1;
        o_stat.err  = (w_status != ST_OK);
        o_stat.cls  = w_cls;
        case (w_cls)
            CLS_OPEN:  o_stat.more = (r_ptr > w_at);
            CLS_CLOSE: o_stat.more = (w_ptr_inc < {1'b0, r_count});
            default:   o_stat.more = 1'b0;
        endcase
    end

    // Memory addresses and write data.
    always_comb begin
        case (w_cls)
            CLS_OPEN:  w_raddr = r_ptr - 1'b1;
            CLS_CLOSE: w_raddr = w_ptr_inc[CW-1:0];
            default:   w_raddr = w_at;
        endcase
        w_waddr = i_cmd.put ? w_at[AW-1:0] : r_ptr[AW-1:0];
        w_wdata = i_cmd.put ? r_val : r_rdata;
    end

    // Entry memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr || i_cmd.put) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[w_raddr[AW-1:0]];
        end
    end

    // Pointer start and step, new count and the result word.
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.check) begin
            n_ptr = (w_cls == CLS_OPEN) ? r_count : w_at;
        end else if (i_cmd.wr) begin
            n_ptr = (w_cls == CLS_OPEN) ? r_ptr - 1'b1 : w_ptr_inc[CW-1:0];
        end

        n_count = r_count;
        if (w_status == ST_OK) begin
            if (w_cls == CLS_OPEN)       n_count = r_count + 1'b1;
            else if (w_cls == CLS_CLOSE) n_count = r_count - 1'b1;
        end

        n_result.value_out = ((w_status == ST_OK) && (w_cls == CLS_READ)) ?
                             r_rdata : '0;
        n_result.count     = 5'(n_count);
        n_result.is_empty  = (n_count == '0);
        n_result.status    = w_status;
    end

    // Request latch, move pointer and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.req_type;
            r_val  <= i_req.value_in;
            r_idx  <= i_req.index_in;
        end
        r_ptr <= n_ptr;
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    // Count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

/* rtl/core/olt_ctrl.sv */
// ----------------------------------------------------------------------------
// olt_ctrl: sequencing state machine for the ordered list table
// Accepts a request, walks the entry moves one at a time and then
// commits the count and issues the result.
// ----------------------------------------------------------------------------
module olt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  olt_pkg::t_stat i_stat,
    output olt_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import olt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_MOVE  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WR    = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.err)                n_state = S_FIN;
                else if (i_stat.cls == CLS_READ) n_state = S_RD;
                else                           n_state = S_MOVE;
            end
            S_MOVE: begin
                if (i_stat.more)                 n_state = S_RD;
                else if (i_stat.cls == CLS_OPEN) n_state = S_PUT;
                else                             n_state = S_FIN;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = (i_stat.cls == CLS_READ) ? S_FIN : S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_MOVE;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
